### rtl/cds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_pkg
// Shared codes and controller/datapath interface types for the c-scan
// disk arm scheduler.
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam int STATUS_BITS = 3;

   // word kinds on the request side
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_GRANTED = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_QUEUED  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_HANDED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_IDLE    = 3'd4;

   typedef struct packed {
      logic capture;     // latch request word, clear scan results
      logic scan_issue;  // read slot at scan index, advance index
      logic commit;      // update queue state, load result register
   } cmd_type;

   typedef struct packed {
      logic grant_fast;  // incoming word is a request and the disk is free
      logic idx_last;    // scan index sits on the last slot
   } stat_type;

endpackage

### rtl/cds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer for the scheduler: accepts a word, runs the slot scan when
// needed and hands the result to the output register.
// ----------------------------------------------------------------------------
module cds_ctrl
   import cds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = stat.grant_fast ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.idx_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last slot read is evaluated here
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/cds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cds_datapath
// Slot queue (valid and upper bits in flops, requester and track in a
// memory), sweep state, scan comparators and the result register.
// ----------------------------------------------------------------------------
module cds_datapath
   import cds_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TRACK_BITS  = 16,
   parameter int ID_BITS     = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   req_kind,
   input  logic [ID_BITS-1:0]     req_id,
   input  logic [TRACK_BITS-1:0]  req_track,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [ID_BITS-1:0]     rsp_grant_id,
   output logic [TRACK_BITS-1:0]  rsp_grant_track,
   output logic                   rsp_busy
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int MEM_W = ID_BITS + TRACK_BITS;

   // slot memory: {requester, track}
   logic [MEM_W-1:0] slot_mem [QUEUE_DEPTH];
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [MEM_W-1:0] mem_wd;
   logic [MEM_W-1:0] mem_rd_ff;

   logic [QUEUE_DEPTH-1:0] vld_ff, vld_in;
   logic [QUEUE_DEPTH-1:0] up_ff, up_in;
   logic                   held_ff, held_in;
   logic [TRACK_BITS-1:0]  last_ff, last_in;

   // captured word
   logic                  kind_ff, kind_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [TRACK_BITS-1:0] trk_ff, trk_in;

   // scan pipeline
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pipe_ff, pipe_in;
   logic [IDX_W-1:0] e_idx_ff, e_idx_in;
   logic             e_vld_ff, e_vld_in;
   logic             e_up_ff, e_up_in;

   // scan results
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  up_found_ff, up_found_in;
   logic [IDX_W-1:0]      up_idx_ff, up_idx_in;
   logic [ID_BITS-1:0]    up_id_ff, up_id_in;
   logic [TRACK_BITS-1:0] up_trk_ff, up_trk_in;
   logic                  all_found_ff, all_found_in;
   logic [IDX_W-1:0]      all_idx_ff, all_idx_in;
   logic [ID_BITS-1:0]    all_id_ff, all_id_in;
   logic [TRACK_BITS-1:0] all_trk_ff, all_trk_in;

   // result register
   logic [STATUS_BITS-1:0] st_ff, st_in;
   logic [ID_BITS-1:0]     gid_ff, gid_in;
   logic [TRACK_BITS-1:0]  gtrk_ff, gtrk_in;
   logic                   busy_ff, busy_in;

   logic [ID_BITS-1:0]    rd_id;
   logic [TRACK_BITS-1:0] rd_trk;
   logic [IDX_W-1:0]      sel_idx;
   logic [ID_BITS-1:0]    sel_id;
   logic [TRACK_BITS-1:0] sel_trk;

   assign rd_id  = mem_rd_ff[MEM_W-1:TRACK_BITS];
   assign rd_trk = mem_rd_ff[TRACK_BITS-1:0];

   // lowest smallest upper entry, or after the wrap the lowest smallest entry
   assign sel_idx = up_found_ff ? up_idx_ff : all_idx_ff;
   assign sel_id  = up_found_ff ? up_id_ff  : all_id_ff;
   assign sel_trk = up_found_ff ? up_trk_ff : all_trk_ff;

   assign stat.grant_fast = (req_kind == KIND_REQUEST) && !held_ff;
   assign stat.idx_last   = (idx_ff == IDX_W'(QUEUE_DEPTH - 1));

   assign rsp_status      = st_ff;
   assign rsp_grant_id    = gid_ff;
   assign rsp_grant_track = gtrk_ff;
   assign rsp_busy        = busy_ff;

   always_comb begin
      vld_in        = vld_ff;
      up_in         = up_ff;
      held_in       = held_ff;
      last_in       = last_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      trk_in        = trk_ff;
      idx_in        = idx_ff;
      pipe_in       = cmd.scan_issue;
      e_idx_in      = e_idx_ff;
      e_vld_in      = e_vld_ff;
      e_up_in       = e_up_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      up_found_in   = up_found_ff;
      up_idx_in     = up_idx_ff;
      up_id_in      = up_id_ff;
      up_trk_in     = up_trk_ff;
      all_found_in  = all_found_ff;
      all_idx_in    = all_idx_ff;
      all_id_in     = all_id_ff;
      all_trk_in    = all_trk_ff;
      st_in         = st_ff;
      gid_in        = gid_ff;
      gtrk_in       = gtrk_ff;
      busy_in       = busy_ff;
      mem_we        = 1'b0;
      mem_wa        = free_idx_ff;
      mem_wd        = {id_ff, trk_ff};

      if (cmd.capture) begin
         kind_in       = req_kind;
         id_in         = req_id;
         trk_in        = req_track;
         idx_in        = '0;
         free_found_in = 1'b0;
         up_found_in   = 1'b0;
         all_found_in  = 1'b0;
      end

      if (cmd.scan_issue) begin
         idx_in   = idx_ff + IDX_W'(1);
         e_idx_in = idx_ff;
         e_vld_in = vld_ff[idx_ff];
         e_up_in  = up_ff[idx_ff];
      end

      // one slot evaluated per cycle, a step behind the memory read
      if (pipe_ff) begin
         if (!e_vld_ff && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = e_idx_ff;
         end
         if (e_vld_ff && (!all_found_ff || (rd_trk < all_trk_ff))) begin
            all_found_in = 1'b1;
            all_idx_in   = e_idx_ff;
            all_id_in    = rd_id;
            all_trk_in   = rd_trk;
         end
         if (e_vld_ff && e_up_ff && (!up_found_ff || (rd_trk < up_trk_ff))) begin
            up_found_in = 1'b1;
            up_idx_in   = e_idx_ff;
            up_id_in    = rd_id;
            up_trk_in   = rd_trk;
         end
      end

      if (cmd.commit) begin
         gid_in  = '0;
         gtrk_in = '0;
         if (kind_ff == KIND_REQUEST) begin
            priority if (!held_ff) begin
               held_in = 1'b1;
               last_in = trk_ff;
               st_in   = ST_GRANTED;
               gid_in  = id_ff;
               gtrk_in = trk_ff;
            end else if (free_found_ff) begin
               vld_in[free_idx_ff] = 1'b1;
               up_in[free_idx_ff]  = (trk_ff >= last_ff);
               mem_we              = 1'b1;
               st_in               = ST_QUEUED;
            end else begin
               st_in = ST_FULL;
            end
         end else begin
            if (all_found_ff) begin
               // no upper entry left: the sweep wraps
               if (!up_found_ff) begin
                  up_in = '1;
               end
               vld_in[sel_idx] = 1'b0;
               held_in         = 1'b1;
               last_in         = sel_trk;
               st_in           = ST_HANDED;
               gid_in          = sel_id;
               gtrk_in         = sel_trk;
            end else begin
               held_in = 1'b0;
               st_in   = ST_IDLE;
            end
         end
         busy_in = held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= slot_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         held_ff       <= 1'b0;
         last_ff       <= '0;
         pipe_ff       <= 1'b0;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         up_found_ff   <= 1'b0;
         all_found_ff  <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         held_ff       <= held_in;
         last_ff       <= last_in;
         pipe_ff       <= pipe_in;
         idx_ff        <= idx_in;
         free_found_ff <= free_found_in;
         up_found_ff   <= up_found_in;
         all_found_ff  <= all_found_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff       <= up_in;
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      trk_ff      <= trk_in;
      e_idx_ff    <= e_idx_in;
      e_vld_ff    <= e_vld_in;
      e_up_ff     <= e_up_in;
      free_idx_ff <= free_idx_in;
      up_idx_ff   <= up_idx_in;
      up_id_ff    <= up_id_in;
      up_trk_ff   <= up_trk_in;
      all_idx_ff  <= all_idx_in;
      all_id_ff   <= all_id_in;
      all_trk_ff  <= all_trk_in;
      st_ff       <= st_in;
      gid_ff      <= gid_in;
      gtrk_ff     <= gtrk_in;
      busy_ff     <= busy_in;
   end

endmodule

### rtl/c_scan_disk_arm_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_scan_disk_arm_scheduler
// Grants one disk to requesters in one-way elevator (c-scan) order.
// ----------------------------------------------------------------------------
// Each request or release word yields exactly one response word. A request
// that finds the disk free goes from S_IDLE straight to S_FINISH; every
// other word walks the slot queue one slot per cycle through the read port
// of the slot memory, through S_SCAN and S_DRAIN. One word is worked on at a
// time; the next word can be taken while the previous response still waits
// in the output register. A release grants the waiting upper entry with the
// smallest track (lowest slot on a tie), turning all lower entries upper
// first if none is upper. There is no owner check on a release.
// ----------------------------------------------------------------------------
module c_scan_disk_arm_scheduler
   import cds_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int TRACK_BITS  = 16,
   parameter int ID_BITS     = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // requester_id, track
   input  logic [((ID_BITS+TRACK_BITS+7)/8)*8-1:0]   req_tdata,
   // kind
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // grant_id, grant_track, busy_res
   output logic [((ID_BITS+TRACK_BITS+1+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0] rsp_tuser
);

   localparam int RSP_W = ((ID_BITS + TRACK_BITS + 1 + 7) / 8) * 8;

   cmd_type               cmd;
   stat_type              stat;
   logic [ID_BITS-1:0]    grant_id;
   logic [TRACK_BITS-1:0] grant_track;
   logic                  busy_res;

   cds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   cds_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TRACK_BITS  (TRACK_BITS),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_tuser),
      .req_id          (req_tdata[ID_BITS-1:0]),
      .req_track       (req_tdata[ID_BITS+TRACK_BITS-1:ID_BITS]),
      .rsp_status      (rsp_tuser),
      .rsp_grant_id    (grant_id),
      .rsp_grant_track (grant_track),
      .rsp_busy        (busy_res)
   );

   assign rsp_tdata = RSP_W'({busy_res, grant_track, grant_id});

endmodule

### dv/tb_c_scan_disk_arm_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_scan_disk_arm_scheduler
// Self-checking bench for the c-scan disk arm scheduler. Request and release
// words go in through the req stream in random bursts while the rsp stream
// stalls on its own pattern. A scoreboard class keeps a copy of the slot
// queue and the sweep position, works out the expected response for every
// accepted word, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_c_scan_disk_arm_scheduler;
   import cds_pkg::*;

   localparam int DEPTH      = 16;
   localparam int HALF_CLK   = 2;
   localparam int RAND_WORDS = 600;
   localparam int LIMIT      = 400000;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [7:0]             grant_id;
      logic [15:0]            grant_track;
      logic                   busy;
   } arm_result_type;

   class disk_arm_scoreboard;
      bit             slot_on [DEPTH];
      bit [7:0]       slot_id [DEPTH];
      bit [15:0]      slot_trk [DEPTH];
      bit             slot_up [DEPTH];
      bit             held;
      bit [15:0]      sweep_trk;
      arm_result_type grants_due[$];
      int unsigned    errors;
      int unsigned    taken;
      int unsigned    status_seen [5];

      // lowest slot with the smallest upper track, -1 if none
      function int nearest_upper();
         int best;
         best = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (slot_on[i] && slot_up[i] && (best < 0 || slot_trk[i] < slot_trk[best]))
               best = i;
         end
         return best;
      endfunction

      function void note_word(bit kind, bit [7:0] rid, bit [15:0] trk);
         arm_result_type r;
         int             free_slot;
         int             best;
         r = '{ST_IDLE, 8'd0, 16'd0, 1'b0};
         taken++;
         if (kind == KIND_REQUEST) begin
            if (!held) begin
               held = 1'b1;
               sweep_trk = trk;
               r.status = ST_GRANTED;
               r.grant_id = rid;
               r.grant_track = trk;
            end else begin
               free_slot = -1;
               for (int i = DEPTH - 1; i >= 0; i--)
                  if (!slot_on[i]) free_slot = i;
               if (free_slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  slot_on[free_slot] = 1'b1;
                  slot_id[free_slot] = rid;
                  slot_trk[free_slot] = trk;
                  slot_up[free_slot] = (trk >= sweep_trk);
                  r.status = ST_QUEUED;
               end
            end
         end else begin
            best = nearest_upper();
            if (best < 0) begin
               // sweep wraps: lower entries join the next pass
               for (int i = 0; i < DEPTH; i++)
                  if (slot_on[i]) slot_up[i] = 1'b1;
               best = nearest_upper();
            end
            if (best < 0) begin
               held = 1'b0;
               r.status = ST_IDLE;
            end else begin
               slot_on[best] = 1'b0;
               held = 1'b1;
               sweep_trk = slot_trk[best];
               r.status = ST_HANDED;
               r.grant_id = slot_id[best];
               r.grant_track = slot_trk[best];
            end
         end
         r.busy = held;
         grants_due.push_back(r);
      endfunction

      function void check_word(logic [STATUS_BITS-1:0] status, logic [31:0] data);
         arm_result_type r;
         if (grants_due.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending: status %0d data %h",
                     $time, status, data);
            return;
         end
         r = grants_due.pop_front();
         if (r.status <= ST_IDLE) status_seen[r.status]++;
         if (status !== r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, r.status, status);
         end
         if (data[7:0] !== r.grant_id) begin
            errors++;
            $display("%0t: grant_id expected %h actual %h", $time, r.grant_id, data[7:0]);
         end
         if (data[23:8] !== r.grant_track) begin
            errors++;
            $display("%0t: grant_track expected %h actual %h",
                     $time, r.grant_track, data[23:8]);
         end
         if (data[24] !== r.busy) begin
            errors++;
            $display("%0t: busy expected %b actual %b", $time, r.busy, data[24]);
         end
      endfunction

      function int pending();
         return grants_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // requester_id, track
   logic        req_tuser = 1'b0; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // grant_id, grant_track, busy_res
   logic [STATUS_BITS-1:0] rsp_tuser; // status

   disk_arm_scoreboard sb = new();
   int unsigned        cycles = 0;

   c_scan_disk_arm_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_CLK clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("c_scan_disk_arm_scheduler test failed");
         $finish;
      end
   end

   // receiver stall pattern, steps through four characters in turn
   always @(negedge clock) begin
      case ((cycles / 256) % 4)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= ((cycles % 23) < 4);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tuser, rsp_tdata);
   end

   task automatic send_word(input bit kind, input bit [7:0] rid, input bit [15:0] trk);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {trk, rid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(kind, rid, trk);
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   initial begin
      int        burst;
      int        phase_left;
      int        req_pct;
      int        trk_mode;
      bit        kind;
      bit [15:0] trk;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // release while idle, with junk in the unused fields
      send_word(KIND_RELEASE, 8'hFF, 16'hFFFF);
      send_word(KIND_REQUEST, 8'hFF, 16'h8000);
      // above, below and equal to the current sweep position
      send_word(KIND_REQUEST, 8'h00, 16'hFFFF);
      send_word(KIND_REQUEST, 8'hAA, 16'h0000);
      send_word(KIND_REQUEST, 8'h55, 16'h8000);
      hold_off(3);
      send_word(KIND_RELEASE, 8'h00, 16'h0000);
      send_word(KIND_RELEASE, 8'h12, 16'h3456);
      // no upper entry left: the sweep wraps to track 0
      send_word(KIND_RELEASE, 8'h00, 16'h0000);
      send_word(KIND_RELEASE, 8'h00, 16'h0000);
      send_word(KIND_RELEASE, 8'h00, 16'h0000);
      // fill the queue with tracks equal to and just below the sweep, then one too many
      send_word(KIND_REQUEST, 8'h01, 16'h0100);
      for (int i = 0; i < DEPTH; i++)
         send_word(KIND_REQUEST, 8'(8'h10 + i), (i % 2) ? 16'h0100 : 16'h00FF);
      send_word(KIND_REQUEST, 8'hEE, 16'h1234);
      hold_off(5);

      phase_left = 0;
      req_pct = 50;
      trk_mode = 0;
      burst = $urandom_range(1, 40);
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
               0: req_pct = 25;
               1: req_pct = 50;
               2: req_pct = 75;
               default: req_pct = 95;
            endcase
            trk_mode = $urandom_range(0, 2);
         end
         phase_left--;
         kind = ($urandom_range(0, 99) < req_pct) ? KIND_REQUEST : KIND_RELEASE;
         case (trk_mode)
            0: trk = 16'($urandom);
            1: begin
               // few distinct tracks to force ties and exact sweep matches
               case ($urandom_range(0, 5))
                  0: trk = 16'h0000;
                  1: trk = 16'h0001;
                  2: trk = 16'h7FFF;
                  3: trk = 16'h8000;
                  4: trk = 16'hFFFE;
                  default: trk = 16'hFFFF;
               endcase
            end
            default: trk = sb.sweep_trk + 16'($urandom_range(0, 8)) - 16'd4;
         endcase
         send_word(kind, 8'($urandom), trk);
         burst--;
         if (burst == 0) begin
            hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : 0);
            burst = $urandom_range(1, 40);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d words: %0d granted, %0d queued, %0d rejected full,",
               sb.taken, sb.status_seen[ST_GRANTED], sb.status_seen[ST_QUEUED],
               sb.status_seen[ST_FULL]);
      $display("  %0d handed over, %0d went idle", sb.status_seen[ST_HANDED],
               sb.status_seen[ST_IDLE]);
      if (sb.errors == 0) begin
         $display("c_scan_disk_arm_scheduler test passed");
      end else begin
         $display("c_scan_disk_arm_scheduler test failed");
      end
      $finish;
   end

endmodule
